// File: src/ort_pkg.sv
// ----------------------------------------------------------------------------
// Ordered route table package
// Shared sizes, codes, entry layout and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package ort_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int KIND_W      = 2;
  localparam int INDEX_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int TOTAL_W     = 5;

  typedef enum logic [KIND_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_PROTECTED = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LSCAN,
    S_ASCAN,
    S_SHIFT,
    S_RCHECK,
    S_CLOSE,
    S_FINISH
  } fsm_state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS_INC,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_ZERO,
    POS_COUNT,
    POS_RADDR,
    POS_IDX
  } pos_op_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_DEC,
    RD_IDX
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NEW,
    WR_UP,
    WR_DOWN
  } wr_sel_e;

  typedef struct packed {
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] hop;
    logic              direct;
  } route_t;

  typedef struct packed {
    logic    req_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    ptr_op_e ptr_op;
    pos_op_e pos_op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_capture;
    status_e res_status;
    logic    res_hit;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              req_direct;
    logic              full;
    logic              idx_ge_count;
    logic              rvalid;
    logic              lk_match;
    logic              ins_match;
    logic              rdirect;
    logic              ptr_lt_count;
    logic              ptr_gt_pos;
    logic              out_busy;
  } ctrl_stat_t;

endpackage

// File: src/ort_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one route table request word.
// ----------------------------------------------------------------------------
interface ort_req_if;
  logic                            valid;
  logic                            ready;
  logic [ort_pkg::KIND_W-1:0]      req_type;
  logic [ort_pkg::ADDR_W-1:0]      route_mask;
  logic [ort_pkg::ADDR_W-1:0]      route_net;
  logic [ort_pkg::ADDR_W-1:0]      route_next_hop;
  logic                            route_direct;
  logic [ort_pkg::INDEX_W-1:0]     entry_index;
  logic [ort_pkg::ADDR_W-1:0]      dest_ip;

  modport source (
    output valid, req_type, route_mask, route_net, route_next_hop, route_direct,
           entry_index, dest_ip,
    input  ready
  );

  modport sink (
    input  valid, req_type, route_mask, route_net, route_next_hop, route_direct,
           entry_index, dest_ip,
    output ready
  );
endinterface

// File: src/ort_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one route table response word.
// ----------------------------------------------------------------------------
interface ort_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ort_pkg::STATUS_W-1:0]  status;
  logic [ort_pkg::ADDR_W-1:0]    next_hop;
  logic                          hit_direct;
  logic [ort_pkg::TOTAL_W-1:0]   entry_total;

  modport source (
    output valid, status, next_hop, hit_direct, entry_total,
    input  ready
  );

  modport sink (
    input  valid, status, next_hop, hit_direct, entry_total,
    output ready
  );
endinterface

// File: src/ort_datapath.sv
// ----------------------------------------------------------------------------
// Ordered route table datapath
// Entry memory, walk pointers, entry count, compare logic and the result and
// output registers.
// ----------------------------------------------------------------------------
module ort_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ort_pkg::KIND_W-1:0]    req_type_i,
  input  logic [ort_pkg::ADDR_W-1:0]    route_mask_i,
  input  logic [ort_pkg::ADDR_W-1:0]    route_net_i,
  input  logic [ort_pkg::ADDR_W-1:0]    route_next_hop_i,
  input  logic                          route_direct_i,
  input  logic [ort_pkg::INDEX_W-1:0]   entry_index_i,
  input  logic [ort_pkg::ADDR_W-1:0]    dest_ip_i,
  input  ort_pkg::ctrl_cmd_t            cmd_i,
  output ort_pkg::ctrl_stat_t           stat_o,
  input  logic                          rsp_ready_i,
  output logic                          rsp_valid_o,
  output logic [ort_pkg::STATUS_W-1:0]  status_o,
  output logic [ort_pkg::ADDR_W-1:0]    next_hop_o,
  output logic                          hit_direct_o,
  output logic [ort_pkg::TOTAL_W-1:0]   entry_total_o
);

  ort_pkg::route_t route_mem [ort_pkg::TABLE_DEPTH];

  logic [ort_pkg::KIND_W-1:0]   kind_q;
  ort_pkg::route_t              new_q;
  logic [ort_pkg::INDEX_W-1:0]  idx_q;
  logic [ort_pkg::ADDR_W-1:0]   dest_q;

  logic [ort_pkg::CNT_W-1:0]    count_q, count_d;
  logic [ort_pkg::CNT_W-1:0]    ptr_q, ptr_d;
  logic [ort_pkg::CNT_W-1:0]    pos_q, pos_d;
  logic [ort_pkg::CNT_W-1:0]    raddr_q;
  logic                         rvalid_q;
  ort_pkg::route_t              rdata_q;

  logic [ort_pkg::CNT_W-1:0]    rd_addr;
  logic [ort_pkg::CNT_W-1:0]    wr_addr;
  ort_pkg::route_t              wr_data;

  logic [ort_pkg::STATUS_W-1:0] res_status_q;
  logic [ort_pkg::ADDR_W-1:0]   res_hop_q;
  logic                         res_hit_q;
  logic [ort_pkg::TOTAL_W-1:0]  res_total_q;

  logic                         out_valid_q;
  logic [ort_pkg::STATUS_W-1:0] out_status_q;
  logic [ort_pkg::ADDR_W-1:0]   out_hop_q;
  logic                         out_hit_q;
  logic [ort_pkg::TOTAL_W-1:0]  out_total_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q        <= req_type_i;
      new_q.mask    <= route_mask_i;
      new_q.net     <= route_net_i;
      new_q.hop     <= route_next_hop_i;
      new_q.direct  <= route_direct_i;
      idx_q         <= entry_index_i;
      dest_q        <= dest_ip_i;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      ort_pkg::RD_PTR:     rd_addr = ptr_q;
      ort_pkg::RD_PTR_DEC: rd_addr = ptr_q - ort_pkg::CNT_W'(1);
      ort_pkg::RD_IDX:     rd_addr = ort_pkg::CNT_W'(idx_q);
      default:             rd_addr = ptr_q;
    endcase
  end

  always_comb begin
    wr_data = rdata_q;
    case (cmd_i.wr_sel)
      ort_pkg::WR_NEW: begin
        wr_addr = pos_q;
        wr_data = new_q;
      end
      ort_pkg::WR_UP:   wr_addr = raddr_q + ort_pkg::CNT_W'(1);
      ort_pkg::WR_DOWN: wr_addr = raddr_q - ort_pkg::CNT_W'(1);
      default:          wr_addr = pos_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= route_mem[rd_addr[ort_pkg::IDX_W-1:0]];
      raddr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      route_mem[wr_addr[ort_pkg::IDX_W-1:0]] <= wr_data;
    end
  end

  always_comb begin
    case (cmd_i.ptr_op)
      ort_pkg::PTR_ZERO:    ptr_d = '0;
      ort_pkg::PTR_COUNT:   ptr_d = count_q;
      ort_pkg::PTR_POS_INC: ptr_d = pos_q + ort_pkg::CNT_W'(1);
      ort_pkg::PTR_INC:     ptr_d = ptr_q + ort_pkg::CNT_W'(1);
      ort_pkg::PTR_DEC:     ptr_d = ptr_q - ort_pkg::CNT_W'(1);
      default:              ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.pos_op)
      ort_pkg::POS_ZERO:  pos_d = '0;
      ort_pkg::POS_COUNT: pos_d = count_q;
      ort_pkg::POS_RADDR: pos_d = raddr_q;
      ort_pkg::POS_IDX:   pos_d = ort_pkg::CNT_W'(idx_q);
      default:            pos_d = pos_q;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + ort_pkg::CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - ort_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      pos_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      pos_q    <= pos_d;
      rvalid_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_capture) begin
      res_status_q <= cmd_i.res_status;
      res_total_q  <= ort_pkg::TOTAL_W'(count_d);
      if (cmd_i.res_hit) begin
        res_hop_q <= rdata_q.hop;
        res_hit_q <= rdata_q.direct;
      end else begin
        res_hop_q <= '0;
        res_hit_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_hop_q    <= res_hop_q;
      out_hit_q    <= res_hit_q;
      out_total_q  <= res_total_q;
    end
  end

  always_comb begin
    stat_o.kind         = kind_q;
    stat_o.req_direct   = new_q.direct;
    stat_o.full         = (count_q == ort_pkg::CNT_W'(ort_pkg::TABLE_DEPTH));
    stat_o.idx_ge_count = (32'(idx_q) >= 32'(count_q));
    stat_o.rvalid       = rvalid_q;
    stat_o.lk_match     = ((rdata_q.mask & dest_q) == rdata_q.net);
    stat_o.ins_match    = !rdata_q.direct && (rdata_q.mask <= new_q.mask);
    stat_o.rdirect      = rdata_q.direct;
    stat_o.ptr_lt_count = (ptr_q < count_q);
    stat_o.ptr_gt_pos   = (ptr_q > pos_q);
    stat_o.out_busy     = out_valid_q && !rsp_ready_i;
  end

  assign rsp_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign next_hop_o    = out_hop_q;
  assign hit_direct_o  = out_hit_q;
  assign entry_total_o = out_total_q;

endmodule

// File: src/ort_controller.sv
// ----------------------------------------------------------------------------
// Ordered route table controller
// Sequences lookup scans, insertion search and shifts, and removal with
// compaction, one entry per cycle.
// ----------------------------------------------------------------------------
module ort_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  ort_pkg::ctrl_stat_t  stat_i,
  output logic                 req_ready_o,
  output ort_pkg::ctrl_cmd_t   cmd_o
);

  ort_pkg::fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ort_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;

    case (state_q)
      ort_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ort_pkg::S_DECODE;
        end
      end

      ort_pkg::S_DECODE: begin
        case (stat_i.kind)
          ort_pkg::REQ_ADD: begin
            if (stat_i.full) begin
              cmd_o.res_capture = 1'b1;
              cmd_o.res_status  = ort_pkg::STAT_FULL;
              state_d           = ort_pkg::S_FINISH;
            end else if (stat_i.req_direct) begin
              cmd_o.pos_op = ort_pkg::POS_ZERO;
              cmd_o.ptr_op = ort_pkg::PTR_COUNT;
              state_d      = ort_pkg::S_SHIFT;
            end else begin
              cmd_o.ptr_op = ort_pkg::PTR_ZERO;
              state_d      = ort_pkg::S_ASCAN;
            end
          end
          ort_pkg::REQ_REMOVE: begin
            if (stat_i.idx_ge_count) begin
              cmd_o.res_capture = 1'b1;
              cmd_o.res_status  = ort_pkg::STAT_NOT_FOUND;
              state_d           = ort_pkg::S_FINISH;
            end else begin
              cmd_o.pos_op = ort_pkg::POS_IDX;
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = ort_pkg::RD_IDX;
              state_d      = ort_pkg::S_RCHECK;
            end
          end
          ort_pkg::REQ_LOOKUP: begin
            cmd_o.ptr_op = ort_pkg::PTR_ZERO;
            state_d      = ort_pkg::S_LSCAN;
          end
          default: begin
            cmd_o.res_capture = 1'b1;
            cmd_o.res_status  = ort_pkg::STAT_NOT_FOUND;
            state_d           = ort_pkg::S_FINISH;
          end
        endcase
      end

      ort_pkg::S_LSCAN: begin
        if (stat_i.rvalid && stat_i.lk_match) begin
          cmd_o.res_capture = 1'b1;
          cmd_o.res_status  = ort_pkg::STAT_OK;
          cmd_o.res_hit     = 1'b1;
          state_d           = ort_pkg::S_FINISH;
        end else if (stat_i.ptr_lt_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ort_pkg::RD_PTR;
          cmd_o.ptr_op = ort_pkg::PTR_INC;
        end else if (!stat_i.rvalid) begin
          cmd_o.res_capture = 1'b1;
          cmd_o.res_status  = ort_pkg::STAT_NOT_FOUND;
          state_d           = ort_pkg::S_FINISH;
        end
      end

      ort_pkg::S_ASCAN: begin
        if (stat_i.rvalid && stat_i.ins_match) begin
          cmd_o.pos_op = ort_pkg::POS_RADDR;
          cmd_o.ptr_op = ort_pkg::PTR_COUNT;
          state_d      = ort_pkg::S_SHIFT;
        end else if (stat_i.ptr_lt_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ort_pkg::RD_PTR;
          cmd_o.ptr_op = ort_pkg::PTR_INC;
        end else if (!stat_i.rvalid) begin
          cmd_o.pos_op = ort_pkg::POS_COUNT;
          cmd_o.ptr_op = ort_pkg::PTR_COUNT;
          state_d      = ort_pkg::S_SHIFT;
        end
      end

      ort_pkg::S_SHIFT: begin
        if (stat_i.rvalid) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ort_pkg::WR_UP;
        end
        if (stat_i.ptr_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ort_pkg::RD_PTR_DEC;
          cmd_o.ptr_op = ort_pkg::PTR_DEC;
        end else if (!stat_i.rvalid) begin
          cmd_o.wr_en       = 1'b1;
          cmd_o.wr_sel      = ort_pkg::WR_NEW;
          cmd_o.cnt_inc     = 1'b1;
          cmd_o.res_capture = 1'b1;
          cmd_o.res_status  = ort_pkg::STAT_OK;
          state_d           = ort_pkg::S_FINISH;
        end
      end

      ort_pkg::S_RCHECK: begin
        if (stat_i.rdirect) begin
          cmd_o.res_capture = 1'b1;
          cmd_o.res_status  = ort_pkg::STAT_PROTECTED;
          state_d           = ort_pkg::S_FINISH;
        end else begin
          cmd_o.ptr_op = ort_pkg::PTR_POS_INC;
          state_d      = ort_pkg::S_CLOSE;
        end
      end

      ort_pkg::S_CLOSE: begin
        if (stat_i.rvalid) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = ort_pkg::WR_DOWN;
        end
        if (stat_i.ptr_lt_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ort_pkg::RD_PTR;
          cmd_o.ptr_op = ort_pkg::PTR_INC;
        end else if (!stat_i.rvalid) begin
          cmd_o.cnt_dec     = 1'b1;
          cmd_o.res_capture = 1'b1;
          cmd_o.res_status  = ort_pkg::STAT_OK;
          state_d           = ort_pkg::S_FINISH;
        end
      end

      ort_pkg::S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ort_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ort_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: src/ordered_route_table.sv
// ----------------------------------------------------------------------------
// Ordered route table
// How long a request occupies the block is set by the walk over the entry
// memory, one entry per cycle; a full table, a bad index or an unused kind
// ends it at decode with no walk. One request is in work at a time; the next
// is taken while the previous response waits. Reset empties the table at once.
// ----------------------------------------------------------------------------
module ordered_route_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  ort_req_if.sink   req_i,
  ort_rsp_if.source rsp_o
);

  ort_pkg::ctrl_cmd_t  cmd;
  ort_pkg::ctrl_stat_t stat;
  logic                req_ready;

  assign req_i.ready = req_ready;

  ort_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .stat_i      (stat),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  ort_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (req_i.req_type),
    .route_mask_i     (req_i.route_mask),
    .route_net_i      (req_i.route_net),
    .route_next_hop_i (req_i.route_next_hop),
    .route_direct_i   (req_i.route_direct),
    .entry_index_i    (req_i.entry_index),
    .dest_ip_i        (req_i.dest_ip),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .status_o         (rsp_o.status),
    .next_hop_o       (rsp_o.next_hop),
    .hit_direct_o     (rsp_o.hit_direct),
    .entry_total_o    (rsp_o.entry_total)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered route table testbench
// Runs a directed sequence, then sends add, remove, lookup and unused-kind
// requests in random bursts while the response side stalls on its own pattern.
// A scoreboard keeps a shadow copy of the table, works out each response as
// its request is accepted, and compares each response word by field in order.
// ----------------------------------------------------------------------------
module tb;
  import ort_pkg::*;

  localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_DIRECT   = 4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  net;
    logic [ADDR_W-1:0]  hop;
    logic               direct;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  dest;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  hop;
    logic               hit;
    logic [TOTAL_W-1:0] total;
  } response_t;

  class route_ledger;
    logic [ADDR_W-1:0] mask_tab[TABLE_DEPTH];
    logic [ADDR_W-1:0] net_tab[TABLE_DEPTH];
    logic [ADDR_W-1:0] hop_tab[TABLE_DEPTH];
    logic              direct_tab[TABLE_DEPTH];
    int                entry_cnt;
    response_t         pending_rsp[$];
    int unsigned       mismatches;

    function new();
      entry_cnt = 0;
      mismatches = 0;
    endfunction

    function int direct_total();
      int n;
      n = 0;
      for (int i = 0; i < entry_cnt; i++) begin
        if (direct_tab[i]) begin
          n++;
        end
      end
      return n;
    endfunction

    function status_e insert_route(request_t r);
      int pos;
      pos = 0;
      if (entry_cnt >= TABLE_DEPTH) begin
        return STAT_FULL;
      end
      if (!r.direct) begin
        while (pos < entry_cnt && direct_tab[pos]) pos++;
        while (pos < entry_cnt && mask_tab[pos] > r.mask) pos++;
      end
      for (int i = entry_cnt; i > pos; i--) begin
        mask_tab[i]   = mask_tab[i-1];
        net_tab[i]    = net_tab[i-1];
        hop_tab[i]    = hop_tab[i-1];
        direct_tab[i] = direct_tab[i-1];
      end
      mask_tab[pos]   = r.mask;
      net_tab[pos]    = r.net;
      hop_tab[pos]    = r.hop;
      direct_tab[pos] = r.direct;
      entry_cnt++;
      return STAT_OK;
    endfunction

    function status_e drop_route(int pos);
      if (pos >= entry_cnt) begin
        return STAT_NOT_FOUND;
      end
      if (direct_tab[pos]) begin
        return STAT_PROTECTED;
      end
      for (int i = pos; i + 1 < entry_cnt; i++) begin
        mask_tab[i]   = mask_tab[i+1];
        net_tab[i]    = net_tab[i+1];
        hop_tab[i]    = hop_tab[i+1];
        direct_tab[i] = direct_tab[i+1];
      end
      entry_cnt--;
      return STAT_OK;
    endfunction

    function void note_request(request_t r);
      response_t exp;
      bit        found;
      exp.status = STAT_NOT_FOUND;
      exp.hop = '0;
      exp.hit = 1'b0;
      found = 1'b0;
      case (r.kind)
        REQ_ADD: begin
          exp.status = insert_route(r);
        end
        REQ_REMOVE: begin
          exp.status = drop_route(int'(r.index));
        end
        REQ_LOOKUP: begin
          for (int i = 0; i < entry_cnt && !found; i++) begin
            if ((mask_tab[i] & r.dest) == net_tab[i]) begin
              found = 1'b1;
              exp.status = STAT_OK;
              exp.hop = hop_tab[i];
              exp.hit = direct_tab[i];
            end
          end
        end
        default: ;
      endcase
      exp.total = TOTAL_W'(entry_cnt);
      pending_rsp.push_back(exp);
    endfunction

    function void check_response(response_t got);
      response_t exp;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected response word: status %0d hop %h hit %0d total %0d",
                   got.status, got.hop, got.hit, got.total);
        end
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.status != exp.status || got.hop != exp.hop || got.hit != exp.hit ||
          got.total != exp.total) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Response mismatch at %0t: expected status %0d hop %h hit %0d total %0d,",
                   $realtime, exp.status, exp.hop, exp.hit, exp.total);
          $display("  got status %0d hop %h hit %0d total %0d",
                   got.status, got.hop, got.hit, got.total);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ort_req_if req_if ();
  ort_rsp_if rsp_if ();

  ordered_route_table DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  route_ledger ledger;
  response_t   seen;
  int          burst_left = 0;
  int unsigned random_sent = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      seen.status = status_e'(rsp_if.status);
      seen.hop = rsp_if.next_hop;
      seen.hit = rsp_if.hit_direct;
      seen.total = rsp_if.entry_total;
      ledger.check_response(seen);
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
      2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= (stall_left[1:0] == 2'd0);
    endcase
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(int unsigned len);
    return (len == 0) ? '0 : ('1 << (ADDR_W - len));
  endfunction

  function automatic request_t make_word(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] mask,
                                         logic [ADDR_W-1:0] net, logic [ADDR_W-1:0] hop,
                                         logic direct, logic [INDEX_W-1:0] index,
                                         logic [ADDR_W-1:0] dest);
    request_t r;
    r.kind = kind;
    r.mask = mask;
    r.net = net;
    r.hop = hop;
    r.direct = direct;
    r.index = index;
    r.dest = dest;
    return r;
  endfunction

  function automatic request_t random_word(logic [KIND_W-1:0] kind);
    return make_word(kind, $urandom, $urandom, $urandom, 1'($urandom),
                     INDEX_W'($urandom), $urandom);
  endfunction

  function automatic request_t random_add();
    request_t    r;
    int unsigned sel;
    r = random_word(REQ_ADD);
    r.direct = (ledger.direct_total() < MAX_DIRECT) && ($urandom_range(0, 99) < 8);
    sel = $urandom_range(0, 99);
    if (sel >= 10) begin
      if (r.direct) begin
        r.mask = prefix_mask($urandom_range(16, 32));
      end else if (sel < 40 && ledger.entry_cnt > 0) begin
        r.mask = ledger.mask_tab[$urandom_range(0, ledger.entry_cnt - 1)];
      end else begin
        r.mask = prefix_mask($urandom_range(0, 32));
      end
      r.net = $urandom & r.mask;
    end else if (r.direct) begin
      r.mask = r.mask | prefix_mask(16);
    end
    return r;
  endfunction

  function automatic request_t random_remove();
    request_t r;
    r = random_word(REQ_REMOVE);
    if (ledger.entry_cnt > 0 && $urandom_range(0, 99) < 80) begin
      r.index = INDEX_W'($urandom_range(0, ledger.entry_cnt - 1));
    end
    return r;
  endfunction

  function automatic request_t random_lookup();
    request_t r;
    int       i;
    r = random_word(REQ_LOOKUP);
    if (ledger.entry_cnt > 0 && $urandom_range(0, 99) < 70) begin
      i = $urandom_range(0, ledger.entry_cnt - 1);
      r.dest = ledger.net_tab[i] | ($urandom & ~ledger.mask_tab[i]);
    end
    return r;
  endfunction

  task automatic send_request(input request_t r);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.req_type <= r.kind;
    req_if.route_mask <= r.mask;
    req_if.route_net <= r.net;
    req_if.route_next_hop <= r.hop;
    req_if.route_direct <= r.direct;
    req_if.entry_index <= r.index;
    req_if.dest_ip <= r.dest;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    ledger.note_request(r);
  endtask

  task automatic run_directed();
    send_request(make_word(REQ_LOOKUP, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF));
    send_request(make_word(REQ_REMOVE, '0, '0, '0, 1'b0, 4'd0, '0));
    send_request(make_word(REQ_UNUSED, '1, '1, '1, 1'b1, '1, '1));
    send_request(make_word(REQ_ADD, 32'hFFFF_0000, 32'h0A00_0000, 32'h0A00_00FE, 1'b0, '0, '0));
    send_request(make_word(REQ_ADD, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hFFFF_FFFF, 1'b0, '0, '0));
    send_request(make_word(REQ_ADD, 32'hFFFF_0000, 32'h0B00_0000, 32'h0B00_00FE, 1'b0, '0, '0));
    send_request(make_word(REQ_ADD, 32'h0000_0000, 32'h0000_0000, 32'h7F7F_7F7F, 1'b0, '0, '0));
    send_request(make_word(REQ_ADD, 32'hFFFF_FF00, 32'hC0A8_0100, 32'hC0A8_01FE, 1'b1, '0, '0));
    send_request(make_word(REQ_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h0A00_0001));
    send_request(make_word(REQ_LOOKUP, '0, '0, '0, 1'b0, '0, 32'hC0A8_0105));
    send_request(make_word(REQ_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h0A00_0005));
    send_request(make_word(REQ_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h7F00_0001));
    send_request(make_word(REQ_REMOVE, '0, '0, '0, 1'b0, 4'd0, '0));
    send_request(make_word(REQ_REMOVE, '0, '0, '0, 1'b0, 4'd15, '0));
    send_request(make_word(REQ_REMOVE, '0, '0, '0, 1'b0, 4'd4, '0));
    send_request(make_word(REQ_LOOKUP, '0, '0, '0, 1'b0, '0, 32'h7F00_0001));
    // Fill the table, then try one more add against the full table.
    while (ledger.entry_cnt < TABLE_DEPTH) send_request(random_add());
    send_request(random_add());
  endtask

  task automatic run_random();
    int unsigned mode;
    int unsigned phase_len;
    int unsigned pick;
    int unsigned add_pct;
    int unsigned remove_pct;
    while (random_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 80);
      add_pct = (mode == 0) ? 55 : (mode == 1) ? 15 : 33;
      remove_pct = (mode == 0) ? 15 : (mode == 1) ? 50 : 27;
      for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
          send_request(random_add());
        end else if (pick < add_pct + remove_pct) begin
          send_request(random_remove());
        end else if (pick < 95) begin
          send_request(random_lookup());
        end else begin
          send_request(random_word(REQ_UNUSED));
        end
        random_sent++;
      end
    end
  endtask

  initial begin
    ledger = new();
    rst_n <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.req_type <= REQ_ADD;
    req_if.route_mask <= '0;
    req_if.route_net <= '0;
    req_if.route_next_hop <= '0;
    req_if.route_direct <= 1'b0;
    req_if.entry_index <= '0;
    req_if.dest_ip <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    req_if.valid <= 1'b0;
    while (ledger.pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ort_pkg.sv
src/ort_req_if.sv
src/ort_rsp_if.sv
src/ort_datapath.sv
src/ort_controller.sv
src/ordered_route_table.sv
tb/tb.sv
